FILE: design/sdspi_pkg.sv
// package: sd spi host sequencer types and constants
`timescale 1ns / 1ps
package sdspi_pkg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] block_number;
        logic [7:0]  rx_byte;
        logic [7:0]  write_byte;
    } sdspi_in_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       chip_select;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       want_write_byte;
        logic       done_res;
        logic [2:0] status;
        logic [1:0] card_type;
    } sdspi_out_t;

    typedef enum logic [4:0] {
        PH_IDLE, PH_INIT_CLK, PH_BUSY, PH_BUSY_REL, PH_CMD, PH_NCR, PH_RESP, PH_REL,
        PH_TOKEN, PH_RDATA, PH_RCRC, PH_W_GAP, PH_W_TOKEN, PH_W_DATA, PH_W_CRC,
        PH_W_RESP, PH_FINAL_REL
    } sdspi_phase_t;

    typedef enum logic [1:0] {REQ_NONE, REQ_INIT, REQ_READ, REQ_WRITE} sdspi_req_t;

    typedef enum logic [2:0] {
        C_CMD0, C_CMD8, C_CMD55, C_ACMD41, C_CMD58, C_CMD16, C_CMD17, C_CMD24
    } sdspi_cmd_t;

    localparam logic [1:0] KIND_INIT  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_BYTE  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INIT_ERR = 3'd1;
    localparam logic [2:0] ST_NO_INIT  = 3'd2;
    localparam logic [2:0] ST_REJECT   = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;
    localparam logic [2:0] ST_ERR_TOK  = 3'd5;
    localparam logic [2:0] ST_CRC_ERR  = 3'd6;
    localparam logic [2:0] ST_WR_ERR   = 3'd7;

    localparam logic [1:0] CT_UNKNOWN  = 2'd0;
    localparam logic [1:0] CT_V1       = 2'd1;
    localparam logic [1:0] CT_V2_BYTE  = 2'd2;
    localparam logic [1:0] CT_V2_BLOCK = 2'd3;

    localparam logic REG_DUMMY_CRC  = 1'b0;
    localparam logic REG_TOKEN_WAIT = 1'b1;

    localparam logic [9:0] BLOCK_BYTES = 10'd512;

    function automatic logic [7:0] cmd_code(input sdspi_cmd_t c);
        logic [7:0] v;
        unique case (c)
            C_CMD0:   v = 8'h40;
            C_CMD8:   v = 8'h48;
            C_CMD55:  v = 8'h77;
            C_ACMD41: v = 8'h69;
            C_CMD58:  v = 8'h7a;
            C_CMD16:  v = 8'h50;
            C_CMD17:  v = 8'h51;
            default:  v = 8'h58;
        endcase
        return v;
    endfunction

endpackage

FILE: design/sdspi_input_stage.sv
// input register stage holding one beat for the sequencer
`timescale 1ns / 1ps
module sdspi_input_stage
    import sdspi_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  sdspi_in_t s_data,
    output logic      q_valid,
    input  logic      q_ready,
    output sdspi_in_t q_data
);
    logic      valid_reg;
    sdspi_in_t data_reg;

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= s_data;
        end
    end
endmodule

FILE: design/sdspi_core.sv
// sequencer state and single-pass next-state logic
`timescale 1ns / 1ps
module sdspi_core
    import sdspi_pkg::*;
#(
    parameter int INIT_IDLE_BYTES = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  sdspi_in_t   in_data,
    input  logic [7:0]  dummy_crc,
    input  logic [19:0] token_wait_limit,
    output sdspi_out_t  res
);
    sdspi_phase_t phase_reg, phase_next;
    sdspi_req_t   req_reg, req_next;
    sdspi_cmd_t   cmd_reg, cmd_next;
    logic [9:0]   cnt_reg, cnt_next;
    logic [7:0]   resp_reg [5];
    logic [7:0]   resp_next [5];
    logic [1:0]   type_reg, type_next;
    logic [31:0]  addr_reg, addr_next;
    logic [19:0]  wait_reg, wait_next;
    logic         gen_reg, gen_next;
    logic         len5_reg, len5_next;
    logic [2:0]   fst_reg, fst_next;
    logic         cs_reg, cs_next;
    sdspi_out_t   o;

    logic [7:0] rx;
    logic [7:0] r1;
    logic [7:0] cbyte;
    logic [9:0] cidx;
    logic [9:0] cnt_inc;
    logic [19:0] wait_inc;
    logic [2:0] wr;

    assign rx = in_data.rx_byte;
    assign cnt_inc = cnt_reg + 10'd1;
    assign wait_inc = wait_reg + 20'd1;
    assign wr = rx[3:1];
    assign cidx = (phase_reg == PH_CMD) ? cnt_inc : 10'd0;

    always_comb begin
        case (cidx)
            10'd0:   cbyte = cmd_code(cmd_reg);
            10'd1:   cbyte = addr_reg[31:24];
            10'd2:   cbyte = addr_reg[23:16];
            10'd3:   cbyte = addr_reg[15:8];
            10'd4:   cbyte = addr_reg[7:0];
            default: cbyte = (cmd_reg == C_CMD0) ? 8'h95 :
                             (cmd_reg == C_CMD8) ? 8'h87 : dummy_crc;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        req_next   = req_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        for (int i = 0; i < 5; i++) resp_next[i] = resp_reg[i];
        type_next  = type_reg;
        addr_next  = addr_reg;
        wait_next  = wait_reg;
        gen_next   = gen_reg;
        len5_next  = len5_reg;
        fst_next   = fst_reg;
        cs_next    = cs_reg;
        o          = '0;
        r1         = resp_reg[0];

        if (in_data.kind != KIND_BYTE) begin
            if (phase_reg == PH_IDLE) begin
                if (in_data.kind == KIND_INIT) begin
                    req_next = REQ_INIT; type_next = CT_UNKNOWN; gen_next = 1'b0;
                    cnt_next = '0; phase_next = PH_INIT_CLK;
                    o.tx_byte = 8'hff; o.tx_valid = 1'b1; cs_next = 1'b1;
                end else if (type_reg == CT_UNKNOWN) begin
                    o.done_res = 1'b1; o.status = ST_NO_INIT; cs_next = 1'b1;
                end else begin
                    req_next = (in_data.kind == KIND_READ) ? REQ_READ : REQ_WRITE;
                    cmd_next = (in_data.kind == KIND_READ) ? C_CMD17 : C_CMD24;
                    addr_next = (type_reg == CT_V2_BLOCK) ? in_data.block_number
                                                          : {in_data.block_number[22:0], 9'd0};
                    len5_next = 1'b0; cnt_next = '0; phase_next = PH_BUSY;
                    o.tx_byte = 8'hff; o.tx_valid = 1'b1; cs_next = 1'b0;
                end
            end
        end else if (phase_reg != PH_IDLE) begin
            // default: emit ff with cs low; arms override
            o.tx_byte = 8'hff; o.tx_valid = 1'b1; cs_next = 1'b0;
            // response complete / evaluate folded below
            unique case (phase_reg)
                PH_INIT_CLK: begin
                    cnt_next = cnt_inc;
                    if (cnt_inc < 10'(INIT_IDLE_BYTES)) begin
                        cs_next = 1'b1;
                    end else begin
                        cmd_next = C_CMD0; addr_next = '0; len5_next = 1'b0;
                        cnt_next = '0; phase_next = PH_BUSY;
                    end
                end
                PH_BUSY: begin
                    if (rx == 8'h00) begin
                    end else if (req_reg == REQ_INIT) begin
                        phase_next = PH_BUSY_REL; cs_next = 1'b1;
                    end else begin
                        cnt_next = '0; phase_next = PH_CMD; o.tx_byte = cbyte;
                    end
                end
                PH_BUSY_REL: begin
                    cnt_next = '0; phase_next = PH_CMD; o.tx_byte = cbyte;
                end
                PH_CMD: begin
                    cnt_next = cnt_inc;
                    if (cnt_inc < 10'd6) o.tx_byte = cbyte;
                    else phase_next = PH_NCR;
                end
                PH_NCR, PH_RESP: begin
                    if (phase_reg == PH_NCR && rx == 8'hff) begin
                    end else begin
                        if (phase_reg == PH_NCR) begin
                            resp_next[0] = rx; r1 = rx; cnt_next = 10'd1;
                        end else begin
                            if (cnt_reg < 10'd5) resp_next[3'(cnt_reg)] = rx;
                            cnt_next = cnt_inc;
                        end
                        if (len5_reg && cnt_next < 10'd5) begin
                            phase_next = PH_RESP;
                        end else if (req_reg == REQ_INIT) begin
                            phase_next = PH_REL; cs_next = 1'b1;
                        end else if (r1 != 8'h00) begin
                            fst_next = ST_REJECT; phase_next = PH_FINAL_REL; cs_next = 1'b1;
                        end else if (cmd_reg == C_CMD17) begin
                            wait_next = '0; phase_next = PH_TOKEN;
                        end else begin
                            phase_next = PH_W_GAP;
                        end
                    end
                end
                PH_REL: begin
                    unique case (cmd_reg)
                        C_CMD0: begin
                            if (r1 != 8'h01) phase_next = PH_IDLE;
                            else begin cmd_next = C_CMD8; addr_next = 32'h1aa; end
                        end
                        C_CMD8: begin
                            if ((r1 != 8'h01 && r1 != 8'h05) || (r1 == 8'h01 &&
                                !(resp_reg[4] == 8'haa && resp_reg[3][3:0] == 4'h1)))
                                phase_next = PH_IDLE;
                            else begin
                                gen_next = (r1 == 8'h01); cmd_next = C_CMD55; addr_next = '0;
                            end
                        end
                        C_CMD55: begin
                            cmd_next = C_ACMD41; addr_next = gen_reg ? 32'h4000_0000 : '0;
                        end
                        C_ACMD41: begin
                            if (r1 == 8'h01) begin cmd_next = C_CMD55; addr_next = '0; end
                            else if (r1 != 8'h00) phase_next = PH_IDLE;
                            else if (gen_reg) begin cmd_next = C_CMD58; addr_next = '0; end
                            else begin cmd_next = C_CMD16; addr_next = 32'h200; end
                        end
                        C_CMD58: begin
                            if (r1 != 8'h00) phase_next = PH_IDLE;
                            else if (resp_reg[1][6]) begin
                                type_next = CT_V2_BLOCK; phase_next = PH_IDLE;
                                o.done_res = 1'b1; o.status = ST_OK;
                            end else begin cmd_next = C_CMD16; addr_next = 32'h200; end
                        end
                        default: begin
                            if (r1 != 8'h00) phase_next = PH_IDLE;
                            else begin
                                type_next = gen_reg ? CT_V2_BYTE : CT_V1; phase_next = PH_IDLE;
                                o.done_res = 1'b1; o.status = ST_OK;
                            end
                        end
                    endcase
                    if (phase_next == PH_IDLE) begin
                        if (!o.done_res) begin o.done_res = 1'b1; o.status = ST_INIT_ERR; end
                        req_next = REQ_NONE; cs_next = 1'b1; o.tx_byte = '0; o.tx_valid = 1'b0;
                    end else begin
                        len5_next = (cmd_next == C_CMD8 || cmd_next == C_CMD58);
                        cnt_next = '0; phase_next = PH_BUSY;
                    end
                end
                PH_TOKEN: begin
                    wait_next = wait_inc;
                    if (rx == 8'hff && wait_inc < token_wait_limit) begin
                    end else if (wait_inc >= token_wait_limit) begin
                        fst_next = ST_TIMEOUT; phase_next = PH_FINAL_REL; cs_next = 1'b1;
                    end else if (rx != 8'hfe) begin
                        fst_next = ST_ERR_TOK; phase_next = PH_FINAL_REL; cs_next = 1'b1;
                    end else begin
                        cnt_next = '0; phase_next = PH_RDATA;
                    end
                end
                PH_RDATA: begin
                    o.read_byte = rx; o.read_valid = 1'b1;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= BLOCK_BYTES) begin cnt_next = '0; phase_next = PH_RCRC; end
                end
                PH_RCRC: begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 10'd2) begin
                        fst_next = ST_OK; phase_next = PH_FINAL_REL; cs_next = 1'b1;
                    end
                end
                PH_W_GAP: begin
                    phase_next = PH_W_TOKEN; o.tx_byte = 8'hfe; o.want_write_byte = 1'b1;
                end
                PH_W_TOKEN: begin
                    cnt_next = 10'd1; phase_next = PH_W_DATA;
                    o.tx_byte = in_data.write_byte; o.want_write_byte = 1'b1;
                end
                PH_W_DATA: begin
                    if (cnt_reg < BLOCK_BYTES) begin
                        cnt_next = cnt_inc; o.tx_byte = in_data.write_byte;
                        o.want_write_byte = (cnt_inc < BLOCK_BYTES);
                    end else begin
                        cnt_next = '0; phase_next = PH_W_CRC; o.tx_byte = dummy_crc;
                    end
                end
                PH_W_CRC: begin
                    cnt_next = cnt_inc;
                    if (cnt_inc < 10'd2) o.tx_byte = dummy_crc;
                    else phase_next = PH_W_RESP;
                end
                PH_W_RESP: begin
                    fst_next = (wr == 3'd2) ? ST_OK : (wr == 3'd5) ? ST_CRC_ERR : ST_WR_ERR;
                    phase_next = PH_FINAL_REL; cs_next = 1'b1;
                end
                PH_FINAL_REL: begin
                    phase_next = PH_IDLE; req_next = REQ_NONE; cs_next = 1'b1;
                    o.tx_byte = '0; o.tx_valid = 1'b0; o.done_res = 1'b1; o.status = fst_reg;
                end
                default: begin
                    o.tx_byte = '0; o.tx_valid = 1'b0; cs_next = cs_reg;
                end
            endcase
        end
        o.chip_select = cs_next;
        o.card_type = type_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            req_reg   <= REQ_NONE;
            cmd_reg   <= C_CMD0;
            cnt_reg   <= '0;
            type_reg  <= CT_UNKNOWN;
            addr_reg  <= '0;
            wait_reg  <= '0;
            gen_reg   <= 1'b0;
            len5_reg  <= 1'b0;
            fst_reg   <= ST_OK;
            cs_reg    <= 1'b1;
        end else if (step) begin
            phase_reg <= phase_next;
            req_reg   <= req_next;
            cmd_reg   <= cmd_next;
            cnt_reg   <= cnt_next;
            type_reg  <= type_next;
            addr_reg  <= addr_next;
            wait_reg  <= wait_next;
            gen_reg   <= gen_next;
            len5_reg  <= len5_next;
            fst_reg   <= fst_next;
            cs_reg    <= cs_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            for (int i = 0; i < 5; i++) resp_reg[i] <= resp_next[i];
        end
    end

    assign res = o;
endmodule

FILE: design/sd_card_spi_host_sequencer_unit.sv
// top level: sd card spi-mode host sequencer
//  channel | ports                       | dir
//  input   | s_valid s_ready s_data      | in
//  result  | m_valid m_ready m_data      | out
//  config  | cfg_we cfg_index cfg_data   | in
// one beat in per cycle while the result is not stalled; a beat passes the input
// register, the single pass of the phase logic and then the result register
// aresetn synchronous: phase idle, card type unknown, control registers to defaults
// a stalled result holds the core; the input register still takes one beat if empty
`timescale 1ns / 1ps
module sd_card_spi_host_sequencer_unit
    import sdspi_pkg::*;
#(
    parameter int INIT_IDLE_BYTES = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  sdspi_in_t   s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output sdspi_out_t  m_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data
);
    logic        q_valid, q_ready, step;
    sdspi_in_t   q_data;
    sdspi_out_t  res;
    logic [7:0]  dummy_crc_reg;
    logic [19:0] token_wait_limit_reg;
    logic        out_valid_reg;
    sdspi_out_t  out_data_reg;

    assign q_ready = !out_valid_reg || m_ready;
    assign step    = q_valid && q_ready;

    sdspi_input_stage u_in (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_valid, .q_ready, .q_data
    );

    sdspi_core #(.INIT_IDLE_BYTES(INIT_IDLE_BYTES)) u_core (
        .aclk, .aresetn, .step, .in_data(q_data),
        .dummy_crc(dummy_crc_reg), .token_wait_limit(token_wait_limit_reg), .res
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dummy_crc_reg        <= 8'hff;
            token_wait_limit_reg <= 20'd1000000;
        end else if (cfg_we) begin
            if (cfg_index == REG_DUMMY_CRC) dummy_crc_reg <= cfg_data[7:0];
            else token_wait_limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_ready) begin
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) out_data_reg <= res;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result not held");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> !m_data.tx_valid) else $error("done with transfer");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.done_res |-> m_data.status == ST_OK) else $error("stray status");
    a_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.read_valid |-> m_data.tx_valid && !m_data.chip_select)
        else $error("read byte outside transfer");
endmodule
